[sv/s3c_pkg.sv]
// Shared constants, register codes and stage types of the strided 3x3 convolution core.
`timescale 1ns / 1ps

package s3c_pkg;

	localparam int IMAGE_SIDE = 16;
	localparam int OUT_SIDE   = 7;
	localparam int POS_W      = $clog2(IMAGE_SIDE);
	localparam int IDX_W      = 3;

	// Pixel history: two full rows plus two pixels behind the incoming one.
	localparam int CHAIN_LEN  = 2 * IMAGE_SIDE + 2;

	localparam int W_W        = 16;
	localparam int REG_W      = 3 * W_W;
	localparam int ROW_SUM_W  = W_W + 2;
	localparam int SUM_W      = W_W + 4;
	localparam int VAL_W      = 13;
	localparam int CLAMP_HIGH = 4096;
	localparam int CFG_IDX_W  = 2;

	localparam logic signed [SUM_W-1:0] CLAMP_S = SUM_W'(CLAMP_HIGH);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_KERNEL_TOP = 2'd0,
		CFG_KERNEL_MID = 2'd1,
		CFG_KERNEL_BOT = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic [IDX_W-1:0] row;
		logic [IDX_W-1:0] col;
		logic             last;
	} out_tag_t;

endpackage

[sv/s3c_cell.sv]
// One cell of the pixel history chain: holds one pixel bit, passes it on per pixel.
`timescale 1ns / 1ps

module s3c_cell
	import s3c_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic shift_en,
	input  logic d,
	output logic q
);

	logic bit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_q <= 1'b0;
		end else if (shift_en) begin
			bit_q <= d;
		end
	end

	assign q = bit_q;

endmodule

[sv/s3c_row_sum.sv]
// Select-and-add of one kernel row against three window pixels.
`timescale 1ns / 1ps

module s3c_row_sum
	import s3c_pkg::*;
(
	input  logic                        [2:0]   bits,    // bit 0 = leftmost column
	input  logic                        [REG_W-1:0] weights,
	output logic signed [ROW_SUM_W-1:0]         sum
);

	logic signed [ROW_SUM_W-1:0] term [3];

	always_comb begin
		for (int l = 0; l < 3; l++) begin
			term[l] = bits[l] ? ROW_SUM_W'($signed(weights[l*W_W +: W_W])) : '0;
		end
		sum = term[0] + term[1] + term[2];
	end

endmodule

[sv/strided_conv3x3_clamp_core.sv]
// Top level of the strided 3x3 convolution core with clamped output.
`timescale 1ns / 1ps
//
// Usage:
//  - Input channel (in_valid/in_ready): one binarized pixel per request, raster order,
//    16x16 image. frame_start marks pixel (0,0) and resyncs the position counters.
//  - Config channel (cfg_valid/cfg_ready): cfg_index 0/1/2 selects the top, middle or
//    bottom kernel row; cfg_data holds three signed Q3.12 weights, left column in bits
//    15:0. cfg_ready is always high; index 3 is dropped. Write only while idle.
//  - Output channel (out_valid/out_ready): one clamped sum (0..4096, Q1.12) for every
//    pixel at an even row and even column from 2 on, 7x7 per image, with its output
//    row/column and last on the final one.
//  - Throughput: one pixel per cycle while in_ready is high. The history chain shifts
//    once per accepted pixel and the adder is a two-stage pipeline, so nothing iterates.
//  - Pipeline: two register stages (row sums in stage 1, total and clamp into the output
//    register); out_valid rises once the window completed by the accepted pixel has
//    passed stage 1 and been loaded into the output register.
//  - Stall: when out_ready is low and the output register is full, stage 1 holds and
//    in_ready drops once stage 1 is also full; no request is lost.
//  - Reset: kernel rows, counters, chain and valid flags clear; no clearing pass.

module strided_conv3x3_clamp_core
	import s3c_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,

	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 pixel_bit,
	input  logic                 frame_start,

	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [REG_W-1:0]     cfg_data,

	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [VAL_W-1:0]     conv_value,
	output logic [IDX_W-1:0]     out_row,
	output logic [IDX_W-1:0]     out_col,
	output logic                 last
);

	// Kernel registers
	logic [REG_W-1:0] kern_top_q, kern_mid_q, kern_bot_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kern_top_q <= '0;
			kern_mid_q <= '0;
			kern_bot_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				CFG_KERNEL_TOP: kern_top_q <= cfg_data;
				CFG_KERNEL_MID: kern_mid_q <= cfg_data;
				CFG_KERNEL_BOT: kern_bot_q <= cfg_data;
				default: ;  // out-of-range index: drop the write
			endcase
		end
	end

	// Pipeline flow control
	logic     in_acc;
	logic     out_free;
	logic     s1_valid_s1;
	out_tag_t s1_tag_s1;
	logic signed [ROW_SUM_W-1:0] top_sum_s1, mid_sum_s1, bot_sum_s1;

	assign out_free = !out_valid || out_ready;
	assign in_ready = !s1_valid_s1 || out_free;
	assign in_acc   = in_valid && in_ready;

	// Position of the incoming pixel; frame_start forces (0,0)
	logic [POS_W-1:0] row_q, col_q;
	logic [POS_W-1:0] cur_row, cur_col;
	logic             emit;
	out_tag_t         tag;

	always_comb begin
		cur_row = frame_start ? '0 : row_q;
		cur_col = frame_start ? '0 : col_q;
		tag.row = IDX_W'((cur_row - POS_W'(2)) >> 1);
		tag.col = IDX_W'((cur_col - POS_W'(2)) >> 1);
		tag.last = (tag.row == IDX_W'(OUT_SIDE - 1)) && (tag.col == IDX_W'(OUT_SIDE - 1));
		emit = !cur_row[0] && !cur_col[0] && (cur_row >= POS_W'(2)) && (cur_col >= POS_W'(2))
			&& (((cur_row - POS_W'(2)) >> 1) < POS_W'(OUT_SIDE))
			&& (((cur_col - POS_W'(2)) >> 1) < POS_W'(OUT_SIDE));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (in_acc) begin
			if (cur_col == POS_W'(IMAGE_SIDE - 1)) begin
				col_q <= '0;
				row_q <= (cur_row == POS_W'(IMAGE_SIDE - 1)) ? '0 : cur_row + POS_W'(1);
			end else begin
				col_q <= cur_col + POS_W'(1);
				row_q <= cur_row;
			end
		end
	end

	// Pixel history chain: cell k holds the pixel accepted k+1 requests ago.
	// Rows above sit IMAGE_SIDE and 2*IMAGE_SIDE pixels back; only windows from
	// row 2 of the current frame are used, so no clear is needed on frame_start.
	logic [CHAIN_LEN-1:0] chain;

	for (genvar k = 0; k < CHAIN_LEN; k++) begin : g_chain
		s3c_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.shift_en (in_acc),
			.d        ((k == 0) ? pixel_bit : chain[(k == 0) ? 0 : k - 1]),
			.q        (chain[k])
		);
	end

	// Window taps, bit 0 = column c-2, bit 2 = column c
	logic [2:0] top_bits, mid_bits, bot_bits;

	assign bot_bits = {pixel_bit, chain[0], chain[1]};
	assign mid_bits = {chain[IMAGE_SIDE-1], chain[IMAGE_SIDE], chain[IMAGE_SIDE+1]};
	assign top_bits = {chain[2*IMAGE_SIDE-1], chain[2*IMAGE_SIDE], chain[2*IMAGE_SIDE+1]};

	logic signed [ROW_SUM_W-1:0] top_sum, mid_sum, bot_sum;

	s3c_row_sum u_sum_top (.bits(top_bits), .weights(kern_top_q), .sum(top_sum));
	s3c_row_sum u_sum_mid (.bits(mid_bits), .weights(kern_mid_q), .sum(mid_sum));
	s3c_row_sum u_sum_bot (.bits(bot_bits), .weights(kern_bot_q), .sum(bot_sum));

	// Stage 1: row sums and output tag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
		end else if (in_ready) begin
			s1_valid_s1 <= in_acc && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && emit) begin
			top_sum_s1 <= top_sum;
			mid_sum_s1 <= mid_sum;
			bot_sum_s1 <= bot_sum;
			s1_tag_s1  <= tag;
		end
	end

	// Stage 2: total and clamp into the output register
	logic signed [SUM_W-1:0] total;
	logic [VAL_W-1:0]        clamped;

	always_comb begin
		total = SUM_W'(top_sum_s1) + SUM_W'(mid_sum_s1) + SUM_W'(bot_sum_s1);
		if (total[SUM_W-1]) begin
			clamped = '0;
		end else if (total > CLAMP_S) begin
			clamped = VAL_W'(CLAMP_HIGH);
		end else begin
			clamped = total[VAL_W-1:0];
		end
	end

	logic     out_valid_q;
	logic [VAL_W-1:0] value_q;
	out_tag_t out_tag_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= s1_valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && s1_valid_s1) begin
			value_q   <= clamped;
			out_tag_q <= s1_tag_s1;
		end
	end

	assign out_valid  = out_valid_q;
	assign conv_value = value_q;
	assign out_row    = out_tag_q.row;
	assign out_col    = out_tag_q.col;
	assign last       = out_tag_q.last;

	// Checks
	a_clamp_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (conv_value <= VAL_W'(CLAMP_HIGH)))
		else $error("conv_value above clamp limit");

	a_last_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && last) |->
			(out_row == IDX_W'(OUT_SIDE - 1)) && (out_col == IDX_W'(OUT_SIDE - 1)))
		else $error("last flagged away from the final output position");

	a_frame_sync: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && frame_start) |=> (row_q == '0) && (col_q == POS_W'(1)))
		else $error("frame_start did not resync the position counters");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_s1 && !out_free) |=> (s1_valid_s1 && $stable(s1_tag_s1)
			&& $stable(top_sum_s1) && $stable(mid_sum_s1) && $stable(bot_sum_s1)))
		else $error("stage 1 changed while the output was stalled");

endmodule

[tb/sv/strided_conv3x3_clamp_core_tb.sv]
// Self-checking testbench for the strided 3x3 convolution core with clamped output.
`timescale 1ns / 1ps

module strided_conv3x3_clamp_core_tb
	import s3c_pkg::*;
();

	// Index 3 addresses no kernel row; a write to it must be dropped.
	localparam logic [CFG_IDX_W-1:0] CFG_NO_REG = 2'd3;

	// Cycles the two-stage adder may still hold a window after the last expected result.
	localparam int PIPE_DRAIN = 4;
	localparam int LONG_HOLD  = 300;

	// Flavors of kernel weights, one per test phase.
	typedef enum int {
		W_SMALL_SIGNED,
		W_EXTREME,
		W_FULL_RANDOM,
		W_SMALL_POSITIVE
	} weight_style_t;

	// Who idles in a phase.
	typedef enum int {
		IDLE_NONE,
		IDLE_SENDER,
		IDLE_RECEIVER,
		IDLE_BOTH
	} idle_mode_t;

	typedef struct packed {
		logic [VAL_W-1:0] value;
		logic [IDX_W-1:0] row;
		logic [IDX_W-1:0] col;
		logic             is_last;
	} conv_window_t;

	// Tracks image position and row history, and holds the window sums still owed.
	class window_tracker_t;
		logic [REG_W-1:0]      kernel_row [3];
		logic [IMAGE_SIDE-1:0] older_row;
		logic [IMAGE_SIDE-1:0] prev_row;
		logic [IMAGE_SIDE-1:0] cur_row;
		int                    row_pos;
		int                    col_pos;
		conv_window_t          owed_windows [$];
		int                    mismatches;
		int                    windows_checked;

		function new();
			for (int i = 0; i < 3; i++) kernel_row[i] = '0;
			older_row = '0;
			prev_row = '0;
			cur_row = '0;
			row_pos = 0;
			col_pos = 0;
			mismatches = 0;
			windows_checked = 0;
		endfunction

		function void load_kernel_row(input logic [CFG_IDX_W-1:0] idx,
				input logic [REG_W-1:0] data);
			if (idx <= CFG_KERNEL_BOT) kernel_row[idx] = data;
		endfunction

		// Sum of the weights whose pixel is set in three adjacent columns of one row.
		function int row_weight_sum(input logic [IMAGE_SIDE-1:0] bits,
				input logic [REG_W-1:0] weights, input int first_col);
			int acc;
			logic signed [W_W-1:0] w;
			acc = 0;
			for (int k = 0; k < 3; k++) begin
				w = weights[k*W_W +: W_W];
				if (bits[first_col + k]) acc += w;
			end
			return acc;
		endfunction

		function void note_pixel(input bit pix, input bit fs);
			int total;
			conv_window_t win;
			if (fs) begin
				row_pos = 0;
				col_pos = 0;
				older_row = '0;
				prev_row = '0;
				cur_row = '0;
			end
			if (pix) cur_row[col_pos] = 1'b1;
			if (row_pos >= 2 && col_pos >= 2 && row_pos % 2 == 0 && col_pos % 2 == 0 &&
					(row_pos - 2) / 2 < OUT_SIDE && (col_pos - 2) / 2 < OUT_SIDE) begin
				total = row_weight_sum(older_row, kernel_row[CFG_KERNEL_TOP], col_pos - 2)
					+ row_weight_sum(prev_row, kernel_row[CFG_KERNEL_MID], col_pos - 2)
					+ row_weight_sum(cur_row, kernel_row[CFG_KERNEL_BOT], col_pos - 2);
				if (total < 0) total = 0;
				if (total > CLAMP_HIGH) total = CLAMP_HIGH;
				win.value = VAL_W'(total);
				win.row = IDX_W'((row_pos - 2) / 2);
				win.col = IDX_W'((col_pos - 2) / 2);
				win.is_last = (win.row == OUT_SIDE - 1) && (win.col == OUT_SIDE - 1);
				owed_windows.push_back(win);
			end
			col_pos++;
			if (col_pos >= IMAGE_SIDE) begin
				col_pos = 0;
				older_row = prev_row;
				prev_row = cur_row;
				cur_row = '0;
				row_pos++;
				if (row_pos >= IMAGE_SIDE) row_pos = 0;
			end
		endfunction

		function void check_result(input logic [VAL_W-1:0] value, input logic [IDX_W-1:0] row,
				input logic [IDX_W-1:0] col, input logic is_last);
			conv_window_t want;
			if (owed_windows.size() == 0) begin
				$display("%0t: result with no window owed: value %0d row %0d col %0d last %0b",
					$time, value, row, col, is_last);
				mismatches++;
				return;
			end
			want = owed_windows.pop_front();
			windows_checked++;
			if (value !== want.value) begin
				$display("%0t: conv_value expected %0d, got %0d", $time, want.value, value);
				mismatches++;
			end
			if (row !== want.row) begin
				$display("%0t: out_row expected %0d, got %0d", $time, want.row, row);
				mismatches++;
			end
			if (col !== want.col) begin
				$display("%0t: out_col expected %0d, got %0d", $time, want.col, col);
				mismatches++;
			end
			if (is_last !== want.is_last) begin
				$display("%0t: last expected %0b, got %0b", $time, want.is_last, is_last);
				mismatches++;
			end
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic                 pixel_bit = 1'b0;
	logic                 frame_start = 1'b0;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = CFG_KERNEL_TOP;
	logic [REG_W-1:0]     cfg_data = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic [VAL_W-1:0]     conv_value;
	logic [IDX_W-1:0]     out_row;
	logic [IDX_W-1:0]     out_col;
	logic                 last;

	window_tracker_t tracker = new();

	int gap_pct = 0;
	int stall_pct = 0;
	int hold_left = 0;
	int pixels_sent = 0;
	int settings_used = 0;

	strided_conv3x3_clamp_core u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.pixel_bit  (pixel_bit),
		.frame_start(frame_start),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.conv_value (conv_value),
		.out_row    (out_row),
		.out_col    (out_col),
		.last       (last)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Sample all three channels on the rising edge; inputs only move on the falling edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready) tracker.load_kernel_row(cfg_index, cfg_data);
			if (in_valid && in_ready) tracker.note_pixel(pixel_bit, frame_start);
			if (out_valid && out_ready) tracker.check_result(conv_value, out_row, out_col, last);
		end
	end

	// Output side: hold off for a counted stretch when asked, otherwise stall at random.
	always @(negedge clk) begin
		if (hold_left > 0) begin
			out_ready = 1'b0;
			hold_left--;
		end else begin
			out_ready = ($urandom_range(0, 99) >= stall_pct);
		end
	end

	// Offer one pixel request, keep it steady until taken, return at the next falling edge.
	task automatic send_pixel(input bit pix, input bit fs);
		while ($urandom_range(0, 99) < gap_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		pixel_bit = pix;
		frame_start = fs;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
		pixels_sent++;
	endtask

	task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [REG_W-1:0] data);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// Drop the input, wait for every owed window, then let the adder pipeline empty.
	task automatic wait_idle();
		in_valid = 1'b0;
		while (tracker.owed_windows.size() != 0) @(negedge clk);
		repeat (PIPE_DRAIN) @(negedge clk);
	endtask

	function automatic logic [REG_W-1:0] make_kernel_row(input weight_style_t style);
		logic [REG_W-1:0] row_bits;
		int w;
		for (int k = 0; k < 3; k++) begin
			case (style)
				W_SMALL_SIGNED:   w = $urandom_range(0, 3000) - 1500;
				W_EXTREME: begin
					case ($urandom_range(0, 3))
						0: w = 16'h7FFF;
						1: w = 16'h8000;
						2: w = 16'h0000;
						default: w = 16'hFFFF;
					endcase
				end
				W_FULL_RANDOM:    w = $urandom_range(0, 65535);
				default:          w = $urandom_range(0, 700);
			endcase
			row_bits[k*W_W +: W_W] = w[W_W-1:0];
		end
		return row_bits;
	endfunction

	initial begin
		int density;
		int frag_len;
		weight_style_t style;
		idle_mode_t mode;

		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: strongest positive kernel, then a write to the unused index that must
		// not disturb it. A few stray pixels, then a resync and the shortest run that
		// completes window (0,0); all ones drive the sum far past the upper clamp.
		write_cfg(CFG_KERNEL_TOP, {3{16'h7FFF}});
		write_cfg(CFG_KERNEL_MID, {3{16'h7FFF}});
		write_cfg(CFG_KERNEL_BOT, {3{16'h7FFF}});
		write_cfg(CFG_NO_REG, {REG_W{1'b1}});
		settings_used++;
		send_pixel(1'b1, 1'b1);
		send_pixel(1'b0, 1'b0);
		send_pixel(1'b1, 1'b0);
		for (int k = 0; k < 2 * IMAGE_SIDE + 3; k++) send_pixel(1'b1, k == 0);
		wait_idle();

		// Phases: new kernel, new idle mode, a broken fragment, then a full image.
		// Phase 3 skips the fragment and the frame start, so its image rides on the
		// counter wrap at the end of phase 2's image.
		for (int phase = 0; phase < 5; phase++) begin
			wait_idle();
			style = weight_style_t'(phase % 4);
			mode = idle_mode_t'(phase % 4);
			write_cfg(CFG_KERNEL_TOP, make_kernel_row(style));
			write_cfg(CFG_KERNEL_MID, make_kernel_row(style));
			write_cfg(CFG_KERNEL_BOT, make_kernel_row(style));
			settings_used++;
			gap_pct = (mode == IDLE_SENDER) ? 75 : (mode == IDLE_BOTH) ? 15 : 0;
			stall_pct = (mode == IDLE_RECEIVER) ? 75 : (mode == IDLE_BOTH) ? 15 : 0;

			if (phase != 3) begin
				frag_len = $urandom_range(8, 40);
				for (int k = 0; k < frag_len; k++)
					send_pixel($urandom_range(0, 1),
						(k == 0) ? $urandom_range(0, 1) : ($urandom_range(0, 19) == 0));
			end

			density = $urandom_range(0, 100);
			for (int k = 0; k < IMAGE_SIDE * IMAGE_SIDE; k++) begin
				// Long output hold-off while requests keep coming: fill the pipe.
				if (phase == 0 && k == 40) hold_left = LONG_HOLD;
				// Pause the input mid-image until every owed window is out.
				if (phase == 4 && k == 128) begin
					in_valid = 1'b0;
					while (tracker.owed_windows.size() != 0) @(negedge clk);
				end
				send_pixel($urandom_range(0, 99) < density, (k == 0) && (phase != 3));
			end
		end

		wait_idle();
		$display("Sent %0d pixels under %0d kernel settings; %0d windows checked.",
			pixels_sent, settings_used, tracker.windows_checked);
		$display("Covered resync, counter wrap, clamps at both ends, stalls and hold-offs.");
		if (tracker.mismatches == 0) begin
			$display("strided_conv3x3_clamp_core_tb passed");
		end else begin
			$display("strided_conv3x3_clamp_core_tb failed");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest legal run.
	initial begin
		#3_000_000;
		$display("strided_conv3x3_clamp_core_tb failed");
		$finish;
	end

endmodule

[filelist.f]
sv/s3c_pkg.sv
sv/s3c_cell.sv
sv/s3c_row_sum.sv
sv/strided_conv3x3_clamp_core.sv
tb/sv/strided_conv3x3_clamp_core_tb.sv
